// ===== src/ipt_pkg.sv =====
`timescale 1ns / 1ps

package ipt_pkg;

    // payload widths
    localparam int CHAR_W = 8;
    localparam int NUM_W  = 64;
    localparam int CNT_W  = 8;

    // text length limits, counted in characters
    localparam logic [CNT_W-1:0] MIN_TEXT_LEN = 8'd7;
    localparam logic [CNT_W-1:0] MAX_TEXT_LEN = 8'd128;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 8'hFF;

    // largest accumulator value that can still take another digit
    localparam logic [NUM_W-1:0] ACC_LIMIT = 64'd1844674407370955161;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;

    // scheme prefix, one character per position
    localparam logic [CHAR_W-1:0] PREFIX_CHARS [4] = '{CH_I, CH_P, CH_N, CH_COLON};

    // parser phases
    typedef enum logic [3:0] {
        PH_PREFIX   = 4'd0,
        PH_NODE_WS  = 4'd1,
        PH_NODE_SGN = 4'd2,
        PH_NODE_DIG = 4'd3,
        PH_NODE_END = 4'd4,
        PH_SVC_WS   = 4'd5,
        PH_SVC_SGN  = 4'd6,
        PH_SVC_DIG  = 4'd7,
        PH_SVC_END  = 4'd8,
        PH_FAILED   = 4'd9
    } t_phase;

endpackage

// ===== src/ipt_if.sv =====
`timescale 1ns / 1ps

// character request channel
interface ipt_in_if;
    import ipt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// parse result channel
interface ipt_out_if;
    import ipt_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic [NUM_W-1:0] node_number;
    logic [NUM_W-1:0] service_number;

    modport source (output valid, output status, output node_number,
                    output service_number, input ready);
    modport sink   (input valid, input status, input node_number,
                    input service_number, output ready);
endinterface

// ===== src/ipn_endpoint_text_parser_core.sv =====
`timescale 1ns / 1ps
// Endpoint-ID text parser for "ipn:NODE.SERVICE".
// i_text carries one character per request, last_char set on the final one.
// o_result carries one request per text: status (0 ok, 1 error) and the node
// and service numbers, both zero on error. Each number is read like strtoul
// in base 10: leading white space, optional sign, digits, ignored tail.
// Throughput: one character per cycle unless a final character waits on the
// result register; the digit unit does one multiply-by-ten and add per cycle,
// shared by both number parts. Each accepted character passes through the
// input register and is parsed as it leaves; the final character also loads
// the result register once it is free, driving o_result.valid from there.
// Stall: the result register holds its request until o_result.ready. A
// following text keeps streaming in while it waits; only the next final
// character parks in the input register, and then i_text.ready drops until
// the result register frees up.
// Reset: the parser returns to the prefix phase with counts, accumulators
// and flags cleared, and both the input and result registers empty. After a
// final character the parser is back in that state for the next text.
module ipn_endpoint_text_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipt_in_if.sink     i_text,
    ipt_out_if.source  o_result
);
    import ipt_pkg::*;

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // parser state
    t_phase            r_phase,    n_phase;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [NUM_W-1:0]  r_node_acc, n_node_acc;
    logic [NUM_W-1:0]  r_svc_acc,  n_svc_acc;
    logic              r_node_neg, n_node_neg;
    logic              r_node_dig, n_node_dig;
    logic              r_node_ovf, n_node_ovf;
    logic              r_svc_neg,  n_svc_neg;
    logic              r_svc_dig,  n_svc_dig;
    logic              r_svc_ovf,  n_svc_ovf;

    // result register
    logic              r_out_valid;
    logic              r_out_err;
    logic [NUM_W-1:0]  r_out_node;
    logic [NUM_W-1:0]  r_out_svc;
    logic              r_out_node_neg;
    logic              r_out_svc_neg;

    logic              w_out_free;
    logic              w_in_take;
    logic              w_out_load;
    logic              w_err;

    logic              w_is_space;
    logic              w_is_digit;
    logic              w_is_minus;
    logic              w_is_sign;
    logic              w_at_ws;
    logic              w_in_svc;

    logic [3:0]        w_digit;
    logic [NUM_W-1:0]  w_sel_acc;
    logic              w_acc_over;
    logic [NUM_W-1:0]  w_acc_next;

    // handshake
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_in_take    = r_in_valid && (!r_in_last || w_out_free);
    assign w_out_load   = w_in_take && r_in_last;
    assign i_text.ready = !r_in_valid || w_in_take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_char <= i_text.text_char;
            r_in_last <= i_text.last_char;
        end
    end

    // character classes
    assign w_is_space = (r_in_char == CH_SPACE) || (r_in_char >= CH_TAB && r_in_char <= CH_CR);
    assign w_is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign w_is_minus = (r_in_char == CH_MINUS);
    assign w_is_sign  = w_is_minus || (r_in_char == CH_PLUS);
    assign w_at_ws    = (r_phase == PH_NODE_WS) || (r_phase == PH_SVC_WS);
    assign w_in_svc   = (r_phase == PH_SVC_WS) || (r_phase == PH_SVC_SGN)
                     || (r_phase == PH_SVC_DIG);

    // shared digit unit: acc * 10 + digit with overflow check
    assign w_digit    = r_in_char[3:0];
    assign w_sel_acc  = w_in_svc ? r_svc_acc : r_node_acc;
    assign w_acc_over = (w_sel_acc > ACC_LIMIT) || (w_sel_acc == ACC_LIMIT && w_digit > 4'd5);
    assign w_acc_next = (w_sel_acc << 3) + (w_sel_acc << 1) + {{(NUM_W-4){1'b0}}, w_digit};

    // next parser state
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_node_acc = r_node_acc;
        n_svc_acc  = r_svc_acc;
        n_node_neg = r_node_neg;
        n_node_dig = r_node_dig;
        n_node_ovf = r_node_ovf;
        n_svc_neg  = r_svc_neg;
        n_svc_dig  = r_svc_dig;
        n_svc_ovf  = r_svc_ovf;

        if (w_in_take) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 8'd1;
            end

            unique case (r_phase)
                PH_PREFIX: begin
                    if (r_in_char != PREFIX_CHARS[r_count[1:0]]) begin
                        n_phase = PH_FAILED;
                    end else if (r_count[1:0] == 2'd3) begin
                        n_phase = PH_NODE_WS;
                    end
                end
                PH_NODE_WS, PH_NODE_SGN, PH_NODE_DIG, PH_NODE_END: begin
                    priority if (r_in_char == CH_DOT) begin
                        n_phase = PH_SVC_WS;
                    end else if (r_in_char == CH_NUL) begin
                        n_phase = PH_FAILED;
                    end else if (r_phase == PH_NODE_END) begin
                        n_phase = PH_NODE_END;
                    end else if (w_at_ws && w_is_space) begin
                        n_phase = r_phase;
                    end else if (w_at_ws && w_is_sign) begin
                        n_phase    = PH_NODE_SGN;
                        n_node_neg = r_node_neg | w_is_minus;
                    end else if (w_is_digit) begin
                        n_phase    = PH_NODE_DIG;
                        n_node_dig = 1'b1;
                        if (!r_node_ovf) begin
                            if (w_acc_over) begin
                                n_node_ovf = 1'b1;
                            end else begin
                                n_node_acc = w_acc_next;
                            end
                        end
                    end else begin
                        n_phase = PH_NODE_END;
                    end
                end
                PH_SVC_WS, PH_SVC_SGN, PH_SVC_DIG: begin
                    priority if (w_at_ws && w_is_space) begin
                        n_phase = r_phase;
                    end else if (w_at_ws && w_is_sign) begin
                        n_phase   = PH_SVC_SGN;
                        n_svc_neg = r_svc_neg | w_is_minus;
                    end else if (w_is_digit) begin
                        n_phase   = PH_SVC_DIG;
                        n_svc_dig = 1'b1;
                        if (!r_svc_ovf) begin
                            if (w_acc_over) begin
                                n_svc_ovf = 1'b1;
                            end else begin
                                n_svc_acc = w_acc_next;
                            end
                        end
                    end else begin
                        n_phase = PH_SVC_END;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // final verdict from the state after the last character
    assign w_err = (n_count < MIN_TEXT_LEN) || (n_count > MAX_TEXT_LEN)
                || !((n_phase == PH_SVC_WS) || (n_phase == PH_SVC_SGN)
                  || (n_phase == PH_SVC_DIG) || (n_phase == PH_SVC_END))
                || !n_node_dig || n_node_ovf || !n_svc_dig || n_svc_ovf;

    // parser state register, cleared again after each text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_out_load) begin
            r_phase    <= PH_PREFIX;
            r_count    <= '0;
            r_node_acc <= '0;
            r_svc_acc  <= '0;
            r_node_neg <= 1'b0;
            r_node_dig <= 1'b0;
            r_node_ovf <= 1'b0;
            r_svc_neg  <= 1'b0;
            r_svc_dig  <= 1'b0;
            r_svc_ovf  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_node_acc <= n_node_acc;
            r_svc_acc  <= n_svc_acc;
            r_node_neg <= n_node_neg;
            r_node_dig <= n_node_dig;
            r_node_ovf <= n_node_ovf;
            r_svc_neg  <= n_svc_neg;
            r_svc_dig  <= n_svc_dig;
            r_svc_ovf  <= n_svc_ovf;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_err      <= w_err;
            r_out_node     <= w_err ? '0 : n_node_acc;
            r_out_svc      <= w_err ? '0 : n_svc_acc;
            r_out_node_neg <= !w_err && n_node_neg;
            r_out_svc_neg  <= !w_err && n_svc_neg;
        end
    end

    // sign applied on the way out, modulo 2^64
    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out_err;
    assign o_result.node_number    = r_out_node_neg ? (64'd0 - r_out_node) : r_out_node;
    assign o_result.service_number = r_out_svc_neg ? (64'd0 - r_out_svc) : r_out_svc;

    // a result appears only after a final character was parsed
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_in_take && r_in_last))
        else $error("result appeared without a final character");

    // the parser is back at the prefix after each text
    a_reset_after_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_phase == PH_PREFIX) && (r_count == '0))
        else $error("parser not cleared after final character");

    // a failed text stays failed until its final character
    a_failed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAILED) && !w_out_load |=> (r_phase == PH_FAILED))
        else $error("parser left the failed phase early");

    // an accepted request always lands in the input register
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_text.valid && i_text.ready |=> r_in_valid)
        else $error("accepted request lost");

endmodule
